[hw/rtl/pic_pkg.sv]
// pic_pkg: shared types, constants and helpers of the polyline interval clipper.
// Used by pic_lane, pic_ctrl and polyline_interval_clipper; depends on nothing.
`default_nettype none

package pic_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int CW          = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
  localparam int CW_SHIFT    = 32 - CW;
  localparam int NUM_LANES   = 3;
  localparam int MUL_STEPS   = 32;
  localparam int DIV_STEPS   = 33;

  typedef logic [31:0] word_t;

  typedef enum logic [1:0] {
    REG_DOMAIN_LOW, REG_DOMAIN_HIGH, REG_TOLERANCE, REG_COORD_COUNT
  } reg_idx_e;

  typedef struct packed {
    logic signed [31:0] domain_low;
    logic signed [31:0] domain_high;
    logic [15:0]        tolerance;
    logic [1:0]         coord_count;
  } cfg_t;

  typedef struct packed {
    logic        start;
    logic [31:0] num;
    logic [31:0] den;
  } lane_req_t;

  // coordinate taken as a CW-bit two's complement value
  function automatic word_t coord_ext(input word_t v);
    word_t s;
    s = v << CW_SHIFT;
    return word_t'($signed(s) >>> CW_SHIFT);
  endfunction

endpackage

`default_nettype wire

[hw/rtl/polyline_interval_clipper.sv]
// polyline_interval_clipper: top level, APB register file, control and three lanes.
// Depends on pic_pkg, pic_lane and pic_ctrl.
//
//   channel   handshake                 word
//   in        in_valid_i / in_stall_o   param_t, coord_x/y/z, last_point
//   out       out_valid_o / out_stall_i vertex_x/y/z, vertex_valid, ends_curve, last_of_run
//   config    APB psel/penable/pwrite   domain_low, domain_high, tolerance, coord_count
//
// One point at a time: a prepare and a decide state, then its result words in the emit state.
// A cut vertex is worked out by the lanes in steps: 1 diff,
// 32 bit-serial multiply steps, 33 restoring divide steps, 1 final add;
// the three coordinates run in parallel.
// Reset (rst_ni low, async) clears the previous point and loads register defaults.
// A stalled output word holds; the next point is taken once the last word is registered.
`default_nettype none

module polyline_interval_clipper
  import pic_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [31:0] param_t_i,
  input  wire logic [31:0] coord_x_i,
  input  wire logic [31:0] coord_y_i,
  input  wire logic [31:0] coord_z_i,
  input  wire logic        last_point_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      vertex_x_o,
  output logic [31:0]      vertex_y_o,
  output logic [31:0]      vertex_z_o,
  output logic             vertex_valid_o,
  output logic             ends_curve_o,
  output logic             last_of_run_o
);

  cfg_t      cfg_q;
  lane_req_t lane_req;
  word_t     p1 [NUM_LANES];
  word_t     p2 [NUM_LANES];
  word_t     lane_res [NUM_LANES];
  logic [NUM_LANES-1:0] lane_done;
  reg_idx_e  ridx;

  assign ridx   = reg_idx_e'(paddr[3:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.domain_low  <= 32'sd0;
      cfg_q.domain_high <= 32'sd65536;
      cfg_q.tolerance   <= 16'd1;
      cfg_q.coord_count <= 2'd3;
    end else if (psel && penable && pwrite && pready) begin
      unique case (ridx)
        REG_DOMAIN_LOW:  cfg_q.domain_low  <= pwdata;
        REG_DOMAIN_HIGH: cfg_q.domain_high <= pwdata;
        REG_TOLERANCE:   cfg_q.tolerance   <= pwdata[15:0];
        REG_COORD_COUNT: cfg_q.coord_count <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_DOMAIN_LOW:  prdata = cfg_q.domain_low;
      REG_DOMAIN_HIGH: prdata = cfg_q.domain_high;
      REG_TOLERANCE:   prdata = {16'd0, cfg_q.tolerance};
      REG_COORD_COUNT: prdata = {30'd0, cfg_q.coord_count};
      default:         prdata = '0;
    endcase
  end

  pic_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .param_t_i      (param_t_i),
    .coord_x_i      (coord_x_i),
    .coord_y_i      (coord_y_i),
    .coord_z_i      (coord_z_i),
    .last_point_i   (last_point_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .vertex_x_o     (vertex_x_o),
    .vertex_y_o     (vertex_y_o),
    .vertex_z_o     (vertex_z_o),
    .vertex_valid_o (vertex_valid_o),
    .ends_curve_o   (ends_curve_o),
    .last_of_run_o  (last_of_run_o),
    .lane_req_o     (lane_req),
    .p1_o           (p1),
    .p2_o           (p2),
    .lane_done_i    (lane_done),
    .lane_res_i     (lane_res)
  );

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    pic_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .req_i  (lane_req),
      .x1_i   (p1[g]),
      .x2_i   (p2[g]),
      .done_o (lane_done[g]),
      .res_o  (lane_res[g])
    );
  end

endmodule

`default_nettype wire

[hw/rtl/pic_lane.sv]
// pic_lane: one coordinate of the cut vertex, x1 + round(|x2-x1|*num/den) signed.
// Bit-serial shift-add multiply then restoring divide; uses pic_pkg.
`default_nettype none

module pic_lane
  import pic_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire lane_req_t req_i,
  input  wire word_t     x1_i,
  input  wire word_t     x2_i,
  output logic           done_o,
  output word_t          res_o
);

  typedef enum logic [2:0] {L_IDLE, L_DIFF, L_MUL, L_DIV, L_ADD} lstate_e;

  lstate_e            state_q;
  logic signed [32:0] x1_q, x2_q;
  logic [31:0]        lo_q, den_q, rem_q;
  logic [33:0]        hi_q;
  logic [32:0]        mag_q, dv_q;
  logic               neg_q;
  logic [5:0]         cnt_q;
  word_t              res_q;

  logic signed [33:0] diff_a, diff_b, add_res;
  logic [32:0]        mag_nx;
  logic [34:0]        mul_sum;
  logic [33:0]        hi_nx;
  logic [31:0]        lo_nx;
  logic [32:0]        div_t, div_r;
  logic               div_ge;

  always_comb begin
    diff_a  = 34'(x2_q) - 34'(x1_q);
    diff_b  = 34'(x1_q) - 34'(x2_q);
    mag_nx  = diff_a[33] ? diff_b[32:0] : diff_a[32:0];
    mul_sum = {1'b0, hi_q} + (lo_q[0] ? {2'b00, mag_q} : 35'd0);
    hi_nx   = mul_sum[34:1];
    lo_nx   = {mul_sum[0], lo_q[31:1]};
    div_t   = {rem_q, dv_q[32]};
    div_ge  = div_t >= {1'b0, den_q};
    div_r   = div_ge ? (div_t - {1'b0, den_q}) : div_t;
    add_res = neg_q ? (34'(x1_q) - $signed({1'b0, dv_q}))
                    : (34'(x1_q) + $signed({1'b0, dv_q}));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      x1_q    <= '0;
      x2_q    <= '0;
      lo_q    <= '0;
      den_q   <= '0;
      rem_q   <= '0;
      hi_q    <= '0;
      mag_q   <= '0;
      dv_q    <= '0;
      neg_q   <= 1'b0;
      cnt_q   <= '0;
      res_q   <= '0;
    end else begin
      unique case (state_q)
        L_IDLE: begin
          if (req_i.start) begin
            x1_q    <= $signed({x1_i[31], x1_i});
            x2_q    <= $signed({x2_i[31], x2_i});
            lo_q    <= req_i.num;
            den_q   <= req_i.den;
            state_q <= L_DIFF;
          end
        end
        L_DIFF: begin
          neg_q   <= diff_a[33];
          mag_q   <= mag_nx;
          hi_q    <= {3'b000, den_q[31:1]};  // rounding half, shifted down by the multiply
          cnt_q   <= '0;
          state_q <= L_MUL;
        end
        L_MUL: begin
          hi_q <= hi_nx;
          lo_q <= lo_nx;
          if (cnt_q == 6'(MUL_STEPS - 1)) begin
            rem_q   <= hi_nx[32:1];
            dv_q    <= {hi_nx[0], lo_nx};
            cnt_q   <= '0;
            state_q <= L_DIV;
          end else begin
            cnt_q <= cnt_q + 6'd1;
          end
        end
        L_DIV: begin
          rem_q <= div_r[31:0];
          dv_q  <= {dv_q[31:0], div_ge};
          if (cnt_q == 6'(DIV_STEPS - 1)) begin
            state_q <= L_ADD;
          end else begin
            cnt_q <= cnt_q + 6'd1;
          end
        end
        L_ADD: begin
          res_q   <= add_res[31:0];
          state_q <= L_IDLE;
        end
        default: state_q <= L_IDLE;
      endcase
    end
  end

  assign done_o = (state_q == L_IDLE);
  assign res_o  = res_q;

endmodule

`default_nettype wire

[hw/rtl/pic_ctrl.sv]
// pic_ctrl: segment rules, previous point, result plan and output word register.
// Starts the pic_lane units for a cut vertex; uses pic_pkg.
`default_nettype none

module pic_ctrl
  import pic_pkg::*;
(
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire cfg_t           cfg_i,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire word_t          param_t_i,
  input  wire word_t          coord_x_i,
  input  wire word_t          coord_y_i,
  input  wire word_t          coord_z_i,
  input  wire logic           last_point_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output word_t               vertex_x_o,
  output word_t               vertex_y_o,
  output word_t               vertex_z_o,
  output logic                vertex_valid_o,
  output logic                ends_curve_o,
  output logic                last_of_run_o,
  output lane_req_t           lane_req_o,
  output word_t               p1_o [NUM_LANES],
  output word_t               p2_o [NUM_LANES],
  input  wire logic [NUM_LANES-1:0] lane_done_i,
  input  wire word_t          lane_res_i [NUM_LANES]
);

  typedef enum logic [1:0] {C_IDLE, C_PREP, C_DECIDE, C_EMIT} cstate_e;
  typedef enum logic [1:0] {SRC_P1, SRC_P2, SRC_CUT, SRC_MARK} src_e;

  cstate_e            state_q;
  word_t              t2_q, prev_t_q;
  word_t              p2_q [NUM_LANES];
  word_t              prev_p_q [NUM_LANES];
  logic               last_q, have_prev_q;
  logic signed [33:0] lbt_q, lbm_q, ubt_q, nlo_q, nhi_q, den_q;
  src_e               kinds_q [3];
  logic [1:0]         n_q, idx_q;
  logic               out_valid_q, vvalid_q, ends_q, lor_q;
  word_t              vout_q [NUM_LANES];

  logic signed [33:0] t1w, t2w, lbw, ubw, tolw;
  logic               case_a, case_b, cut, cut_lerp, fin;
  src_e               kinds_d [3];
  logic [1:0]         n_d;
  logic               out_free, can_load, idx_last, commit, accept;
  src_e               cur;
  word_t              vsel [NUM_LANES];

  always_comb begin
    t1w  = {{2{prev_t_q[31]}}, prev_t_q};
    t2w  = {{2{t2_q[31]}}, t2_q};
    lbw  = {{2{cfg_i.domain_low[31]}}, cfg_i.domain_low};
    ubw  = {{2{cfg_i.domain_high[31]}}, cfg_i.domain_high};
    tolw = $signed({18'd0, cfg_i.tolerance});

    case_a   = have_prev_q && (nlo_q > 34'sd0) && (t2w > lbt_q);
    case_b   = have_prev_q && !case_a && (t1w > lbm_q) && (t1w < ubt_q);
    cut      = case_b && (t2w > ubw);
    cut_lerp = cut && (den_q > 34'sd0) && (nhi_q > 34'sd0);
    fin      = last_q && (t2w < ubt_q);

    kinds_d[0] = SRC_MARK;
    kinds_d[1] = SRC_MARK;
    kinds_d[2] = SRC_MARK;
    n_d        = 2'd0;
    if (case_a) begin
      kinds_d[0] = SRC_CUT;
      n_d        = 2'd1;
    end else if (case_b) begin
      kinds_d[0] = SRC_P1;
      n_d        = 2'd1;
      if (cut) begin
        kinds_d[1] = cut_lerp ? SRC_CUT : SRC_P1;
        n_d        = 2'd2;
      end
    end
    if (last_q) begin
      if (fin) begin
        unique case (n_d)
          2'd0:    kinds_d[0] = SRC_P2;
          2'd1:    kinds_d[1] = SRC_P2;
          default: kinds_d[2] = SRC_P2;
        endcase
        n_d = n_d + 2'd1;
      end else if (n_d == 2'd0) begin
        kinds_d[0] = SRC_MARK;
        n_d        = 2'd1;
      end
    end

    lane_req_o.start = (state_q == C_DECIDE) && (case_a || cut_lerp);
    lane_req_o.num   = case_a ? nlo_q[31:0] : nhi_q[31:0];
    lane_req_o.den   = den_q[31:0];

    accept   = in_valid_i && (state_q == C_IDLE);
    out_free = !out_valid_q || !out_stall_i;
    cur      = kinds_q[idx_q];
    idx_last = (idx_q == n_q - 2'd1);
    can_load = (state_q == C_EMIT) && out_free && ((cur != SRC_CUT) || (&lane_done_i));
    commit   = ((state_q == C_DECIDE) && (n_d == 2'd0)) || (can_load && idx_last);

    for (int j = 0; j < NUM_LANES; j++) begin
      unique case (cur)
        SRC_P1:  vsel[j] = prev_p_q[j];
        SRC_P2:  vsel[j] = p2_q[j];
        SRC_CUT: vsel[j] = lane_res_i[j];
        default: vsel[j] = '0;
      endcase
      if (2'(j) >= cfg_i.coord_count) vsel[j] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= C_IDLE;
      t2_q        <= '0;
      prev_t_q    <= '0;
      last_q      <= 1'b0;
      have_prev_q <= 1'b0;
      lbt_q       <= '0;
      lbm_q       <= '0;
      ubt_q       <= '0;
      nlo_q       <= '0;
      nhi_q       <= '0;
      den_q       <= '0;
      n_q         <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      vvalid_q    <= 1'b0;
      ends_q      <= 1'b0;
      lor_q       <= 1'b0;
      for (int j = 0; j < NUM_LANES; j++) begin
        p2_q[j]     <= '0;
        prev_p_q[j] <= '0;
        vout_q[j]   <= '0;
      end
      for (int k = 0; k < 3; k++) kinds_q[k] <= SRC_MARK;
    end else begin
      if (out_valid_q && !out_stall_i && !can_load) out_valid_q <= 1'b0;

      unique case (state_q)
        C_IDLE: begin
          if (accept) begin
            t2_q    <= param_t_i;
            p2_q[0] <= coord_ext(coord_x_i);
            p2_q[1] <= coord_ext(coord_y_i);
            p2_q[2] <= coord_ext(coord_z_i);
            last_q  <= last_point_i;
            state_q <= C_PREP;
          end
        end
        C_PREP: begin
          lbt_q   <= lbw + tolw;
          lbm_q   <= lbw - tolw;
          ubt_q   <= ubw + tolw;
          nlo_q   <= lbw - t1w;
          nhi_q   <= ubw - t1w;
          den_q   <= t2w - t1w;
          state_q <= C_DECIDE;
        end
        C_DECIDE: begin
          for (int k = 0; k < 3; k++) kinds_q[k] <= kinds_d[k];
          n_q     <= n_d;
          idx_q   <= '0;
          state_q <= (n_d == 2'd0) ? C_IDLE : C_EMIT;
        end
        C_EMIT: begin
          if (can_load) begin
            out_valid_q <= 1'b1;
            vvalid_q    <= (cur != SRC_MARK);
            ends_q      <= last_q && idx_last;
            lor_q       <= idx_last;
            for (int j = 0; j < NUM_LANES; j++) vout_q[j] <= vsel[j];
            if (idx_last) state_q <= C_IDLE;
            else idx_q <= idx_q + 2'd1;
          end
        end
        default: state_q <= C_IDLE;
      endcase

      if (commit) begin
        if (last_q) begin
          have_prev_q <= 1'b0;
          prev_t_q    <= '0;
          for (int j = 0; j < NUM_LANES; j++) prev_p_q[j] <= '0;
        end else begin
          have_prev_q <= 1'b1;
          prev_t_q    <= t2_q;
          for (int j = 0; j < NUM_LANES; j++) prev_p_q[j] <= p2_q[j];
        end
      end
    end
  end

  assign in_stall_o     = (state_q != C_IDLE);
  assign out_valid_o    = out_valid_q;
  assign vertex_x_o     = vout_q[0];
  assign vertex_y_o     = vout_q[1];
  assign vertex_z_o     = vout_q[2];
  assign vertex_valid_o = vvalid_q;
  assign ends_curve_o   = ends_q;
  assign last_of_run_o  = lor_q;
  assign p1_o           = prev_p_q;
  assign p2_o           = p2_q;

endmodule

`default_nettype wire

[verif/tb.sv]
// tb: self-checking testbench for polyline_interval_clipper, driven through valid/stall and APB.
// Predicts every vertex word with its own clipping and rounding model; depends on pic_pkg.
// Runs directed curves, then random curves under several register settings and idle patterns.
module tb
  import pic_pkg::*;
();

  localparam int IDLE_LIMIT      = 4000;
  localparam int SETTLE_CYCLES   = 250;
  localparam int HOLD_CYCLES     = 600;
  localparam int MAX_PRINTS      = 100;

  typedef struct {
    word_t x;
    word_t y;
    word_t z;
    logic  vv;
    logic  ends;
    logic  lor;
  } vertex_t;

  typedef word_t coord3_t [3];

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        psel           = 1'b0;
  logic        penable        = 1'b0;
  logic        pwrite         = 1'b0;
  logic [3:0]  paddr          = '0;
  logic [31:0] pwdata         = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i     = 1'b0;
  logic        in_stall_o;
  logic [31:0] param_t_i      = '0;
  logic [31:0] coord_x_i      = '0;
  logic [31:0] coord_y_i      = '0;
  logic [31:0] coord_z_i      = '0;
  logic        last_point_i   = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i    = 1'b1;
  logic [31:0] vertex_x_o;
  logic [31:0] vertex_y_o;
  logic [31:0] vertex_z_o;
  logic        vertex_valid_o;
  logic        ends_curve_o;
  logic        last_of_run_o;

  polyline_interval_clipper u_dut (.*);

  always #5 clk_i = ~clk_i;

  // shadow registers and curve state
  longint     lb_q  = 0;
  longint     ub_q  = 65536;
  longint     tol_q = 1;
  logic [1:0] cnt_q = 2'd3;
  word_t      prev_t = '0;
  coord3_t    prev_c = '{default: '0};
  bit         have_prev = 1'b0;

  vertex_t expected_vertices[$];
  int      mismatch_count = 0;
  int      points_sent    = 0;
  int      vertices_seen  = 0;
  int      send_idle_pct  = 0;
  int      recv_idle_pct  = 0;
  int      hold_left      = 0;
  int      idle_cycles    = 0;

  function automatic longint sval(word_t v);
    return longint'($signed(v));
  endfunction

  function automatic longint cval(word_t v);
    word_t m;
    m = (CW >= 32) ? '1 : word_t'((64'd1 << CW) - 1);
    return v[CW-1] ? sval(v | ~m) : sval(v & m);
  endfunction

  // a + round((b - a) * num / den), ties away from zero
  function automatic word_t interp(word_t a, word_t b, longint num, longint den);
    longint       x1, d, mag;
    logic [127:0] acc, q;
    x1  = cval(a);
    d   = cval(b) - x1;
    mag = (d < 0) ? -d : d;
    acc = 128'(mag) * 128'(num) + 128'(den >>> 1);
    q   = acc / 128'(den);
    return word_t'((d < 0) ? x1 - longint'(q[63:0]) : x1 + longint'(q[63:0]));
  endfunction

  function automatic vertex_t make_vertex(coord3_t c, bit valid);
    vertex_t v;
    v.x    = (valid && cnt_q > 0) ? c[0] : '0;
    v.y    = (valid && cnt_q > 1) ? c[1] : '0;
    v.z    = (valid && cnt_q > 2) ? c[2] : '0;
    v.vv   = valid;
    v.ends = 1'b0;
    v.lor  = 1'b0;
    return v;
  endfunction

  task automatic clip_point(word_t t, coord3_t p, bit last);
    vertex_t res[$];
    longint  t1, t2;
    coord3_t p1, p2, c;
    t2 = sval(t);
    foreach (p2[j]) p2[j] = word_t'(cval(p[j]));
    if (have_prev) begin
      t1 = sval(prev_t);
      foreach (p1[j]) p1[j] = word_t'(cval(prev_c[j]));
      if (t1 < lb_q && t2 > lb_q + tol_q) begin
        foreach (c[j]) c[j] = interp(p1[j], p2[j], lb_q - t1, t2 - t1);
        res.push_back(make_vertex(c, 1'b1));
      end else if (t1 > lb_q - tol_q && t1 < ub_q + tol_q) begin
        res.push_back(make_vertex(p1, 1'b1));
        if (t2 > ub_q) begin
          if (t2 > t1 && ub_q > t1) begin
            foreach (c[j]) c[j] = interp(p1[j], p2[j], ub_q - t1, t2 - t1);
            res.push_back(make_vertex(c, 1'b1));
          end else begin
            res.push_back(make_vertex(p1, 1'b1));
          end
        end
      end
    end
    if (last) begin
      if (t2 < ub_q + tol_q) res.push_back(make_vertex(p2, 1'b1));
      if (res.size() == 0) res.push_back(make_vertex(p2, 1'b0));
      res[res.size()-1].ends = 1'b1;
      have_prev = 1'b0;
      prev_t    = '0;
      prev_c    = '{default: '0};
    end else begin
      prev_t    = t;
      prev_c    = p;
      have_prev = 1'b1;
    end
    if (res.size() > 0) res[res.size()-1].lor = 1'b1;
    foreach (res[k]) expected_vertices.push_back(res[k]);
  endtask

  task automatic report_mismatch(string msg);
    if (mismatch_count < MAX_PRINTS) $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic apb_write(int idx, word_t val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 4'(4 * idx);
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_DOMAIN_LOW:  lb_q  = sval(val);
      REG_DOMAIN_HIGH: ub_q  = sval(val);
      REG_TOLERANCE:   tol_q = longint'(val[15:0]);
      REG_COORD_COUNT: cnt_q = val[1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic send_point(word_t t, coord3_t p, bit last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    param_t_i    <= t;
    coord_x_i    <= p[0];
    coord_y_i    <= p[1];
    coord_z_i    <= p[2];
    last_point_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    clip_point(t, p, last);
    points_sent++;
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_vertices.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic longint rand_below(longint n);
    return longint'({$urandom, $urandom} >> 1) % n;
  endfunction

  function automatic word_t rand_coord();
    case ($urandom_range(0, 3))
      0: return word_t'(sval($urandom_range(0, 2097151)) - 1048576);
      1: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic coord3_t rand_coords();
    coord3_t c;
    foreach (c[j]) c[j] = rand_coord();
    return c;
  endfunction

  function automatic longint near_bound();
    longint base;
    base = $urandom_range(0, 1) ? lb_q : ub_q;
    case ($urandom_range(0, 5))
      0: return base;
      1: return base + tol_q + $urandom_range(0, 2) - 1;
      2: return base - tol_q + $urandom_range(0, 2) - 1;
      3: return base + ($urandom_range(0, 1) ? 1 : -1);
      4: return base + longint'($urandom_range(0, 262143)) - 131072;
      default: return sval($urandom);
    endcase
  endfunction

  // mostly ordered curves sweeping across the window, the rest scattered points
  task automatic random_points(int n);
    longint span, t;
    int     len, k;
    bit     tidy, last;
    k = 0;
    while (k < n) begin
      len  = $urandom_range(1, 6);
      tidy = ($urandom_range(0, 3) != 0);
      span = ub_q - lb_q;
      if (span <= 0) span = 65536;
      t = lb_q - rand_below(span / 2 + 2);
      for (int i = 0; i < len && k < n; i++) begin
        if (tidy) begin
          if (i > 0) t = t + 1 + rand_below(span / 2 + 1);
          last = (i == len - 1);
        end else begin
          t    = near_bound();
          last = (i == len - 1) || ($urandom_range(0, 4) == 0);
        end
        send_point(word_t'(t), rand_coords(), last);
        k++;
      end
    end
  endtask

  task automatic apply_setting(int k);
    word_t      lo, hi;
    logic [15:0] tol;
    logic [1:0]  cnt;
    case (k)
      0: begin
        lo = '0; hi = 32'h0001_0000; tol = '0; cnt = 2'd1;
      end
      1: begin
        lo = 32'h8000_0000; hi = 32'h7fff_ffff; tol = 16'hffff; cnt = 2'd3;
      end
      2: begin
        lo  = word_t'(sval($urandom_range(0, 1048575)) - 524288);
        hi  = lo + $urandom_range(1024, 1 << 20);
        tol = 16'($urandom_range(0, 4095));
        cnt = 2'd2;
      end
      3: begin
        lo = 32'h7fff_ffff; hi = 32'h8000_0000; tol = 16'($urandom); cnt = 2'd0;
      end
      4: begin
        lo = $urandom; hi = $urandom; tol = 16'($urandom); cnt = 2'($urandom);
      end
      default: begin
        lo = word_t'(-262144); hi = 32'd262144; tol = 16'd256; cnt = 2'd3;
      end
    endcase
    apb_write(REG_DOMAIN_LOW, lo);
    apb_write(REG_DOMAIN_HIGH, hi);
    apb_write(REG_TOLERANCE, {16'($urandom), tol});
    apb_write(REG_COORD_COUNT, {30'($urandom), cnt});
  endtask

  // reset window [0, 1.0], tolerance 1, three coordinates
  task automatic test_directed_cases();
    send_point(32'd100, '{32'h0001_0000, 32'hffff_0000, 32'h1234_5678}, 1'b1);
    send_point(32'h7fff_ffff, '{32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff}, 1'b1);
    send_point(word_t'(-65536), '{32'd0, 32'h0010_0000, 32'hfff0_0000}, 1'b0);
    send_point(32'd32768, '{32'h0002_0000, 32'd0, 32'h0000_0003}, 1'b0);
    send_point(32'd131072, '{32'h0004_0000, 32'hffff_fffd, 32'h0001_0001}, 1'b1);
    send_point(word_t'(-65536), '{32'd7, 32'd8, 32'd9}, 1'b0);
    send_point(32'd200000, '{32'h0100_0000, 32'hff00_0000, 32'd1}, 1'b1);
    send_point(32'h8000_0000, '{32'h8000_0000, 32'h7fff_ffff, 32'd0}, 1'b0);
    send_point(32'h7fff_ffff, '{32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff}, 1'b1);
    send_point(word_t'(-200000), '{32'd1, 32'd2, 32'd3}, 1'b0);
    send_point(word_t'(-100000), '{32'd4, 32'd5, 32'd6}, 1'b0);
    send_point(word_t'(-50000), '{32'd7, 32'd8, 32'd9}, 1'b1);
    send_point(32'd300000, '{32'd1, 32'd1, 32'd1}, 1'b0);
    send_point(32'd400000, '{32'd2, 32'd2, 32'd2}, 1'b1);
    // points either side of the lower bound by exactly the tolerance: no cut, only the end point
    send_point(32'hffff_ffff, '{32'd0, 32'd0, 32'd0}, 1'b0);
    send_point(32'd1, '{32'd1, 32'hffff_ffff, 32'd3}, 1'b1);
    wait_idle();
  endtask

  task automatic test_bound_cases();
    apb_write(REG_TOLERANCE, 32'd1000);
    apb_write(REG_COORD_COUNT, 32'd1);
    // upper cut with t1 just above the bound, falling then rising
    send_point(32'd66036, '{32'h0001_1111, 32'd5, 32'd6}, 1'b0);
    send_point(32'd65800, '{32'h0002_2222, 32'd7, 32'd8}, 1'b1);
    send_point(32'd66036, '{32'h0003_3333, 32'd5, 32'd6}, 1'b0);
    send_point(32'd70000, '{32'h0004_4444, 32'd7, 32'd8}, 1'b1);
    wait_idle();
    apb_write(REG_COORD_COUNT, 32'd0);
    send_point(word_t'(-65536), '{32'h0001_0000, 32'h0002_0000, 32'h0003_0000}, 1'b0);
    send_point(32'd32768, '{32'h0005_0000, 32'h0006_0000, 32'h0007_0000}, 1'b1);
    wait_idle();
    apb_write(REG_COORD_COUNT, 32'd2);
    send_point(word_t'(-1000), '{32'h0001_0000, 32'h0002_0000, 32'h0003_0000}, 1'b0);
    send_point(32'd90000, '{32'hfff0_0000, 32'h0010_0000, 32'h0003_0000}, 1'b1);
    wait_idle();
  endtask

  task automatic test_idle_phase(int send_pct, int recv_pct, int set_a, int set_b);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    apply_setting(set_a);
    random_points(65);
    wait_idle();
    apply_setting(set_b);
    random_points(65);
    wait_idle();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left = HOLD_CYCLES;
    random_points(40);
    wait_idle();
  endtask

  task automatic test_pause();
    send_idle_pct = 16;
    recv_idle_pct = 16;
    random_points(20);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_vertices.size() != 0) @(posedge clk_i);
    random_points(20);
    wait_idle();
  endtask

  always @(posedge clk_i) begin : vertex_check
    vertex_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      vertices_seen++;
      if (expected_vertices.size() == 0) begin
        report_mismatch("vertex word with nothing expected");
      end else begin
        want = expected_vertices.pop_front();
        if (vertex_x_o !== want.x)
          report_mismatch($sformatf("vertex_x got %h want %h", vertex_x_o, want.x));
        if (vertex_y_o !== want.y)
          report_mismatch($sformatf("vertex_y got %h want %h", vertex_y_o, want.y));
        if (vertex_z_o !== want.z)
          report_mismatch($sformatf("vertex_z got %h want %h", vertex_z_o, want.z));
        if (vertex_valid_o !== want.vv)
          report_mismatch($sformatf("vertex_valid got %b want %b", vertex_valid_o, want.vv));
        if (ends_curve_o !== want.ends)
          report_mismatch($sformatf("ends_curve got %b want %b", ends_curve_o, want.ends));
        if (last_of_run_o !== want.lor)
          report_mismatch($sformatf("last_of_run got %b want %b", last_of_run_o, want.lor));
      end
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_bound_cases();
    test_idle_phase(16, 81, 0, 2);
    test_idle_phase(81, 16, 1, 3);
    test_idle_phase(0, 0, 4, 5);
    test_backpressure();
    test_pause();
    if (expected_vertices.size() != 0)
      report_mismatch($sformatf("%0d vertex words never arrived", expected_vertices.size()));
    $display("Sent %0d points and checked %0d vertex words over six window settings,",
             points_sent, vertices_seen);
    $display("with both sides idling, a long output hold-off and a drained pause.");
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
